>>> rtl/core/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared constants and types for the depth pixel to point back-projection.
// ----------------------------------------------------------------------------
package dpp_pkg;

	localparam int MAX_IMAGE_DIM = 4096;

	localparam int DEPTH_W   = 16;
	localparam int PIX_W     = 12;
	localparam int Q4_W      = 16;
	localparam int COLOR_W   = 8;
	localparam int COORD_W   = 24;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int DIFF_W     = PIX_W + 5;
	localparam int PROD_W     = DIFF_W + DEPTH_W;
	localparam int MAG_W      = PROD_W - 1;
	localparam int DIV_BITS   = 4;
	localparam int DIV_STAGES = MAG_W / DIV_BITS;
	localparam int PIPE_LAT   = DIV_STAGES + 4;

	localparam logic [PIX_W-1:0] PIX_LIMIT = PIX_W'(MAX_IMAGE_DIM - 1);

	localparam logic [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_ORD = 3'd5;

	localparam logic [Q4_W-1:0]    RST_CENTER    = 16'd0;
	localparam logic [Q4_W-1:0]    RST_FOCAL     = 16'd16;
	localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH = 16'd10000;

	localparam logic COLOR_ORD_BGR = 1'b0;
	localparam logic COLOR_ORD_RGB = 1'b1;

	typedef struct packed {
		logic [DEPTH_W-1:0] z;
		logic               color_valid;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} side_t;

endpackage

>>> rtl/core/dpp_pixel_if.sv
// ----------------------------------------------------------------------------
// dpp_pixel_if
// Input channel carrying one depth pixel with its coordinates and color.
// ----------------------------------------------------------------------------
interface dpp_pixel_if import dpp_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_raw;
	logic [PIX_W-1:0]   pixel_column;
	logic [PIX_W-1:0]   pixel_row;
	logic               color_present;
	logic [COLOR_W-1:0] color_byte_a;
	logic [COLOR_W-1:0] color_byte_b;
	logic [COLOR_W-1:0] color_byte_c;

	modport source (
		output valid, depth_raw, pixel_column, pixel_row, color_present,
		output color_byte_a, color_byte_b, color_byte_c,
		input  ready
	);

	modport sink (
		input  valid, depth_raw, pixel_column, pixel_row, color_present,
		input  color_byte_a, color_byte_b, color_byte_c,
		output ready
	);

endinterface

>>> rtl/core/dpp_point_if.sv
// ----------------------------------------------------------------------------
// dpp_point_if
// Output channel carrying one back-projected point with its color.
// ----------------------------------------------------------------------------
interface dpp_point_if import dpp_pkg::*; ();

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x_mm;
	logic signed [COORD_W-1:0] point_y_mm;
	logic [DEPTH_W-1:0]        point_z_mm;
	logic                      color_valid;
	logic [COLOR_W-1:0]        red;
	logic [COLOR_W-1:0]        green;
	logic [COLOR_W-1:0]        blue;

	modport source (
		output valid, point_x_mm, point_y_mm, point_z_mm, color_valid,
		output red, green, blue,
		input  ready
	);

	modport sink (
		input  valid, point_x_mm, point_y_mm, point_z_mm, color_valid,
		input  red, green, blue,
		output ready
	);

endinterface

>>> rtl/core/dpp_axis.sv
// ----------------------------------------------------------------------------
// dpp_axis
// Pipelined projection of one axis: (pix*16 - center) * depth / focal,
// truncated toward zero and saturated to the signed coordinate width.
// ----------------------------------------------------------------------------
module dpp_axis import dpp_pkg::*; (
	input  logic                      clk,
	input  logic                      en,
	input  logic [PIX_W-1:0]          pix,
	input  logic [Q4_W-1:0]           center,
	input  logic [Q4_W-1:0]           focal,
	input  logic [DEPTH_W-1:0]        depth,
	output logic signed [COORD_W-1:0] coord
);

	logic [PIX_W-1:0]         pix_c;
	logic signed [DIFF_W-1:0] diff_w;

	logic signed [DIFF_W-1:0] diff_s1;
	logic [DEPTH_W-1:0]       depth_s1;
	logic [Q4_W-1:0]          focal_s1;

	logic signed [PROD_W-1:0] prod_w;
	logic signed [PROD_W-1:0] prod_s2;
	logic [Q4_W-1:0]          focal_s2;

	logic [MAG_W-1:0]         abs_w;

	logic [MAG_W-1:0] dv_mag_s  [DIV_STAGES+1];
	logic [Q4_W-1:0]  dv_rem_s  [DIV_STAGES+1];
	logic [Q4_W-1:0]  dv_den_s  [DIV_STAGES+1];
	logic             dv_neg_s  [DIV_STAGES+1];
	logic             dv_zero_s [DIV_STAGES+1];

	logic [MAG_W-1:0] mag_n [DIV_STAGES];
	logic [Q4_W-1:0]  rem_n [DIV_STAGES];

	logic [MAG_W-1:0]   quo;
	logic [COORD_W-1:0] sat_w;
	logic [COORD_W-1:0] coord_q;

	assign pix_c  = (pix > PIX_LIMIT) ? PIX_LIMIT : pix;
	assign diff_w = $signed({1'b0, pix_c, 4'b0000}) - $signed({1'b0, center});

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1  <= diff_w;
			depth_s1 <= depth;
			focal_s1 <= focal;
		end
	end

	assign prod_w = diff_s1 * $signed({1'b0, depth_s1});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2  <= prod_w;
			focal_s2 <= focal_s1;
		end
	end

	assign abs_w = prod_s2[PROD_W-1] ? MAG_W'(-prod_s2) : MAG_W'(prod_s2);

	// Restoring division, DIV_BITS quotient bits per stage. The quotient bits
	// shift into the low end of the dividend word as it empties.
	always_comb begin
		logic [Q4_W:0]    trial;
		logic [MAG_W-1:0] mag_t;
		logic [Q4_W-1:0]  rem_t;
		for (int k = 0; k < DIV_STAGES; k++) begin
			mag_t = dv_mag_s[k];
			rem_t = dv_rem_s[k];
			for (int j = 0; j < DIV_BITS; j++) begin
				trial = {rem_t, mag_t[MAG_W-1]};
				mag_t = {mag_t[MAG_W-2:0], 1'b0};
				if (trial >= {1'b0, dv_den_s[k]}) begin
					trial    = trial - {1'b0, dv_den_s[k]};
					mag_t[0] = 1'b1;
				end
				rem_t = trial[Q4_W-1:0];
			end
			mag_n[k] = mag_t;
			rem_n[k] = rem_t;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_mag_s[0]  <= abs_w;
			dv_rem_s[0]  <= '0;
			dv_den_s[0]  <= focal_s2;
			dv_neg_s[0]  <= prod_s2[PROD_W-1];
			dv_zero_s[0] <= (prod_s2 == '0);
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_mag_s[k+1]  <= mag_n[k];
				dv_rem_s[k+1]  <= rem_n[k];
				dv_den_s[k+1]  <= dv_den_s[k];
				dv_neg_s[k+1]  <= dv_neg_s[k];
				dv_zero_s[k+1] <= dv_zero_s[k];
			end
		end
	end

	// A zero divisor yields an all-ones quotient, which saturates by sign.
	assign quo = dv_mag_s[DIV_STAGES];

	always_comb begin
		if (dv_zero_s[DIV_STAGES]) begin
			sat_w = '0;
		end else if (dv_neg_s[DIV_STAGES]) begin
			if (quo > MAG_W'(COORD_NEG_MIN))
				sat_w = COORD_NEG_MIN;
			else
				sat_w = COORD_W'(~quo + MAG_W'(1));
		end else begin
			if (quo > MAG_W'(COORD_POS_MAX))
				sat_w = COORD_POS_MAX;
			else
				sat_w = quo[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coord_q <= sat_w;
		end
	end

	assign coord = $signed(coord_q);

endmodule

>>> rtl/core/depth_pixel_to_point.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Back-projects depth pixels through a pinhole camera model into 3D points.
//
//   channel  direction  carries
//   pixel    in         depth, column, row, color bytes
//   point    out        x, y, z in mm and red, green, blue
//   cfg_*    in         intrinsics, depth limit, color order
//
// One pixel is accepted per cycle unless the output stalls. Each point passes
// through the stages in order: two stages form the product, one takes its
// magnitude, eight radix-16 divider stages follow and one saturates.
// Pixels with zero or out-of-range depth travel as bubbles and give no point.
// A stall at the output freezes every stage at once, so nothing is lost.
// Reset clears the stage valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module depth_pixel_to_point import dpp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	dpp_pixel_if.sink            pixel,
	dpp_point_if.source          point
);

	logic [Q4_W-1:0]    center_x_q;
	logic [Q4_W-1:0]    center_y_q;
	logic [Q4_W-1:0]    focal_x_q;
	logic [Q4_W-1:0]    focal_y_q;
	logic [DEPTH_W-1:0] max_depth_q;
	logic               color_order_q;

	logic              adv;
	logic              keep;
	side_t             side_w;
	logic [PIPE_LAT-1:0] vld_s;
	side_t             side_s [PIPE_LAT];
	logic signed [COORD_W-1:0] x_w;
	logic signed [COORD_W-1:0] y_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= RST_CENTER;
			center_y_q    <= RST_CENTER;
			focal_x_q     <= RST_FOCAL;
			focal_y_q     <= RST_FOCAL;
			max_depth_q   <= RST_MAX_DEPTH;
			color_order_q <= COLOR_ORD_BGR;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CENTER_X:  center_x_q    <= cfg_data[Q4_W-1:0];
				REG_CENTER_Y:  center_y_q    <= cfg_data[Q4_W-1:0];
				REG_FOCAL_X:   focal_x_q     <= cfg_data[Q4_W-1:0];
				REG_FOCAL_Y:   focal_y_q     <= cfg_data[Q4_W-1:0];
				REG_MAX_DEPTH: max_depth_q   <= cfg_data[DEPTH_W-1:0];
				REG_COLOR_ORD: color_order_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv         = !vld_s[PIPE_LAT-1] || point.ready;
	assign pixel.ready = adv;

	assign keep = pixel.valid && (pixel.depth_raw != '0) && (pixel.depth_raw <= max_depth_q);

	always_comb begin
		side_w.z           = pixel.depth_raw;
		side_w.color_valid = pixel.color_present;
		side_w.green       = pixel.color_present ? pixel.color_byte_b : '0;
		if (!pixel.color_present) begin
			side_w.red  = '0;
			side_w.blue = '0;
		end else if (color_order_q == COLOR_ORD_RGB) begin
			side_w.red  = pixel.color_byte_a;
			side_w.blue = pixel.color_byte_c;
		end else begin
			side_w.red  = pixel.color_byte_c;
			side_w.blue = pixel.color_byte_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PIPE_LAT-2:0], keep};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_w;
			for (int k = 1; k < PIPE_LAT; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	dpp_axis u_axis_x (
		.clk    (clk),
		.en     (adv),
		.pix    (pixel.pixel_column),
		.center (center_x_q),
		.focal  (focal_x_q),
		.depth  (pixel.depth_raw),
		.coord  (x_w)
	);

	dpp_axis u_axis_y (
		.clk    (clk),
		.en     (adv),
		.pix    (pixel.pixel_row),
		.center (center_y_q),
		.focal  (focal_y_q),
		.depth  (pixel.depth_raw),
		.coord  (y_w)
	);

	assign point.valid       = vld_s[PIPE_LAT-1];
	assign point.point_x_mm  = x_w;
	assign point.point_y_mm  = y_w;
	assign point.point_z_mm  = side_s[PIPE_LAT-1].z;
	assign point.color_valid = side_s[PIPE_LAT-1].color_valid;
	assign point.red         = side_s[PIPE_LAT-1].red;
	assign point.green       = side_s[PIPE_LAT-1].green;
	assign point.blue        = side_s[PIPE_LAT-1].blue;

`ifndef SYNTH
	// An emitted point never carries a zero depth.
	a_nonzero_z: assert property (@(posedge clk) disable iff (!arst_n)
		point.valid |-> (point.point_z_mm != '0))
		else $error("point transaction with zero depth");

	// Without color, all color components are zero.
	a_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		(point.valid && !point.color_valid) |->
		(point.red == '0 && point.green == '0 && point.blue == '0))
		else $error("color components set without color");

	// A stalled output freezes the whole pipeline.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[PIPE_LAT-1] && !point.ready) |=> $stable(vld_s))
		else $error("pipeline moved during output stall");

	// A pixel with zero depth enters as a bubble.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready && pixel.depth_raw == '0) |=> !vld_s[0])
		else $error("zero-depth pixel entered the pipeline");
`endif

endmodule
